// ===== rtl/assert_macros.svh =====
// Assertion macros used by the decoder core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define RCFD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RCFD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rcfd_pkg.sv =====
package rcfd_pkg;

    localparam logic [7:0]  FRAME_MARK  = 8'h0F;
    localparam logic [5:0]  FRAME_LEN   = 6'd35;
    localparam logic [5:0]  FLAG_BYTE   = 6'd33;
    localparam logic [5:0]  SUM_BYTE    = 6'd34;
    localparam int          NUM_CH      = 16;
    localparam logic [16:0] CENTER      = 17'd1024;
    localparam logic [16:0] LIMIT       = 17'd842;
    localparam logic [15:0] ONE_Q14     = 16'sd16384;
    localparam logic [14:0] RECIP_MUL   = 15'd19737;
    localparam int          RECIP_SHIFT = 10;
    localparam logic [9:0]  SPAN        = 10'd850;

    typedef struct packed {
        logic       vld;
        logic [3:0] idx;
        logic [3:0] flags;
    } rcfd_tag_t;

endpackage

// ===== rtl/rc_channel_frame_decoder_core.sv =====
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   rx_byte
// output   out        out_valid / out_stall channel_index, channel_value, raw_channel, flags
// Accepted bytes are written to the frame memory until it is full; a frame mark goes to entry zero.
// A mark closing a good frame starts sixteen reads, one channel per cycle on two ports unless stalled.
// Input requests are stalled while reads issue; results pass the read, scale A, scale B and output registers.
// A stall on a valid output freezes the whole scaling pipeline, and reset clears counters and valids.
// The frame memory needs no clearing pass; only written entries are ever read.
`include "assert_macros.svh"

module rc_channel_frame_decoder_core
    import rcfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         channel_index,
    output logic signed [15:0] channel_value,
    output logic [15:0]        raw_channel,
    output logic               failsafe,
    output logic               frame_lost,
    output logic               channel18_bit,
    output logic               aux_flag,
    output logic               last_channel
);

    logic [7:0] frame_mem [0:34];

    logic [5:0] count_reg;
    logic [5:0] count_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic [3:0] flags_reg;
    logic [7:0] sum_reg;
    logic       issuing_reg;
    logic [3:0] issue_cnt_reg;
    logic [3:0] emit_flags_reg;

    rcfd_tag_t   tag1_reg;
    logic [7:0]  rd_hi_reg;
    logic [7:0]  rd_lo_reg;

    rcfd_tag_t          tag_s;
    logic [15:0]        raw_s;
    logic signed [15:0] value_s;

    logic               out_valid_reg;
    logic [3:0]         idx_out_reg;
    logic [3:0]         flags_out_reg;
    logic [15:0]        raw_out_reg;
    logic signed [15:0] value_out_reg;

    logic       accept;
    logic       is_mark;
    logic       good_frame;
    logic [5:0] eff_count;
    logic [7:0] eff_xor;
    logic       en;
    logic [5:0] addr_hi;
    logic [5:0] addr_lo;

    assign in_stall   = issuing_reg;
    assign accept     = in_valid && !issuing_reg;
    assign is_mark    = (rx_byte == FRAME_MARK);
    assign good_frame = is_mark && (count_reg == FRAME_LEN) && (xor_reg == sum_reg);
    assign eff_count  = is_mark ? 6'd0 : count_reg;
    assign eff_xor    = is_mark ? 8'd0 : xor_reg;
    assign en         = !out_valid_reg || !out_stall;
    assign addr_hi    = {1'b0, issue_cnt_reg, 1'b1};
    assign addr_lo    = 6'({issue_cnt_reg, 1'b0}) + 6'd2;

    always_comb
    begin
        count_next = eff_count;
        xor_next   = eff_xor;
        if (eff_count < FRAME_LEN)
        begin
            count_next = eff_count + 6'd1;
            if (eff_count >= 6'd1 && eff_count <= FLAG_BYTE)
                xor_next = eff_xor ^ rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && eff_count < FRAME_LEN)
            frame_mem[eff_count] <= rx_byte;
        if (en && issuing_reg)
        begin
            rd_hi_reg <= frame_mem[addr_hi];
            rd_lo_reg <= frame_mem[addr_lo];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 6'd0;
            xor_reg       <= 8'd0;
            issuing_reg   <= 1'b0;
            issue_cnt_reg <= 4'd0;
            tag1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                xor_reg   <= xor_next;
                if (good_frame)
                begin
                    issuing_reg   <= 1'b1;
                    issue_cnt_reg <= 4'd0;
                end
            end
            if (en)
            begin
                tag1_reg.vld   <= issuing_reg;
                tag1_reg.idx   <= issue_cnt_reg;
                tag1_reg.flags <= emit_flags_reg;
                out_valid_reg  <= tag_s.vld;
                if (issuing_reg)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 4'd1;
                    if (issue_cnt_reg == 4'(NUM_CH - 1))
                        issuing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && eff_count == FLAG_BYTE)
            flags_reg <= rx_byte[3:0];
        if (accept && eff_count == SUM_BYTE)
            sum_reg <= rx_byte;
        if (accept && good_frame)
            emit_flags_reg <= flags_reg;
        if (en)
        begin
            idx_out_reg    <= tag_s.idx;
            flags_out_reg  <= tag_s.flags;
            raw_out_reg    <= raw_s;
            value_out_reg  <= value_s;
        end
    end

    rcfd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tag_in    (tag1_reg),
        .raw_in    ({rd_hi_reg, rd_lo_reg}),
        .tag_out   (tag_s),
        .raw_out   (raw_s),
        .value_out (value_s)
    );

    assign out_valid     = out_valid_reg;
    assign channel_index = idx_out_reg;
    assign channel_value = value_out_reg;
    assign raw_channel   = raw_out_reg;
    assign failsafe      = flags_out_reg[3];
    assign frame_lost    = flags_out_reg[2];
    assign channel18_bit = flags_out_reg[1];
    assign aux_flag      = flags_out_reg[0];
    assign last_channel  = (idx_out_reg == 4'(NUM_CH - 1));

    `RCFD_ASSERT(a_issue_ends, issuing_reg && en && issue_cnt_reg == 4'(NUM_CH - 1) |=> !issuing_reg, "channel reads did not stop after the last channel")
    `RCFD_ASSERT(a_start_on_mark, $rose(issuing_reg) |-> $past(in_valid && !in_stall && rx_byte == FRAME_MARK), "channel reads started without a closing frame mark")
    `RCFD_ASSERT(a_start_at_zero, $rose(issuing_reg) |-> issue_cnt_reg == 4'd0, "channel reads started at a nonzero channel")
    `RCFD_ASSERT(a_count_bound, count_reg <= FRAME_LEN, "frame byte count ran past the frame length")

endmodule

// ===== rtl/rcfd_scale.sv =====
module rcfd_scale
    import rcfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  rcfd_tag_t        tag_in,
    input  logic [15:0]      raw_in,
    output rcfd_tag_t        tag_out,
    output logic [15:0]      raw_out,
    output logic signed [15:0] value_out
);

    logic signed [16:0] diff;
    logic               satp;
    logic               satn;
    logic [16:0]        abs_wide;
    logic [9:0]         absd;

    rcfd_tag_t   tag_a_reg;
    logic [15:0] raw_a_reg;
    logic [24:0] prod_a_reg;
    logic [9:0]  absd_a_reg;
    logic        neg_a_reg;
    logic        satp_a_reg;
    logic        satn_a_reg;

    rcfd_tag_t   tag_b_reg;
    logic [15:0] raw_b_reg;
    logic [14:0] q0_b_reg;
    logic [24:0] qm_b_reg;
    logic [9:0]  absd_b_reg;
    logic        neg_b_reg;
    logic        satp_b_reg;
    logic        satn_b_reg;

    logic [14:0] q0_a;
    logic [24:0] num_b;
    logic [24:0] rem_b;
    logic [14:0] q_b;

    always_comb
    begin
        diff     = $signed({1'b0, raw_in}) - $signed(CENTER);
        satp     = !diff[16] && (diff >= $signed(LIMIT));
        satn     = diff[16] && (diff <= -$signed(LIMIT));
        abs_wide = diff[16] ? 17'(-diff) : 17'(diff);
        absd     = abs_wide[9:0];
    end

    assign q0_a = prod_a_reg[RECIP_SHIFT +: 15];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_a_reg       <= raw_in;
            prod_a_reg      <= 25'(absd) * 25'(RECIP_MUL);
            absd_a_reg      <= absd;
            neg_a_reg       <= diff[16];
            satp_a_reg      <= satp;
            satn_a_reg      <= satn;

            raw_b_reg       <= raw_a_reg;
            q0_b_reg        <= q0_a;
            qm_b_reg        <= 25'(q0_a) * 25'(SPAN);
            absd_b_reg      <= absd_a_reg;
            neg_b_reg       <= neg_a_reg;
            satp_b_reg      <= satp_a_reg;
            satn_b_reg      <= satn_a_reg;
        end
    end

    always_comb
    begin
        num_b = {1'b0, absd_b_reg, 14'd0};
        rem_b = num_b - qm_b_reg;
        q_b   = q0_b_reg + 15'((rem_b >= 25'(SPAN)) ? 1 : 0);
        if (satp_b_reg)
            value_out = ONE_Q14;
        else if (satn_b_reg)
            value_out = -ONE_Q14;
        else if (neg_b_reg)
            value_out = -$signed({1'b0, q_b});
        else
            value_out = $signed({1'b0, q_b});
    end

    assign tag_out = tag_b_reg;
    assign raw_out = raw_b_reg;

endmodule
